// ===== design/s2d_pkg.sv =====
package s2d_pkg;

  // width of one output character code
  localparam int CHAR_W = 6;

  // magnitude bits retired by one double-dabble stage
  localparam int STAGE_BITS = 8;

  // ascii codes, trimmed to the output width
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

  // digit threshold and correction for the shift-and-add-3 step
  localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [3:0] BCD_ADJ_ADD = 4'd3;

endpackage

// ===== design/s2d_sign.sv =====
module s2d_sign
  import s2d_pkg::*;
#(
  parameter int VALUE_BITS = 32,
  parameter int PAD_BITS   = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [VALUE_BITS-1:0] in_value,
  output logic                         busy,
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output logic [PAD_BITS-1:0]          dn_mag,
  output logic                         dn_neg
);

  logic                  valid_r;
  logic                  valid_nxt;
  logic [PAD_BITS-1:0]   mag_r;
  logic                  neg_r;
  logic                  up_ready;
  logic                  accept;
  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag;
  logic [PAD_BITS-1:0]   mag_pad;

  assign up_ready = !valid_r || dn_ready;
  assign accept   = start && up_ready;
  assign busy     = !up_ready;

  // magnitude as unsigned, so the most negative value stays exact
  always_comb begin
    raw = $unsigned(in_value);
    mag = raw[VALUE_BITS-1] ? (~raw + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : raw;
    mag_pad = '0;
    mag_pad[VALUE_BITS-1:0] = mag;
  end

  always_comb begin
    valid_nxt = valid_r;
    if (up_ready) begin
      valid_nxt = start;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mag_r <= mag_pad;
      neg_r <= raw[VALUE_BITS-1];
    end
  end

  assign dn_valid = valid_r;
  assign dn_mag   = mag_r;
  assign dn_neg   = neg_r;

endmodule

// ===== design/s2d_dabble.sv =====
module s2d_dabble
  import s2d_pkg::*;
#(
  parameter int DIGITS   = 10,
  parameter int PAD_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  logic [DIGITS*4-1:0]   up_bcd,
  input  logic [PAD_BITS-1:0]   up_bin,
  input  logic                  up_neg,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output logic [DIGITS*4-1:0]   dn_bcd,
  output logic [PAD_BITS-1:0]   dn_bin,
  output logic                  dn_neg
);

  logic                valid_r;
  logic                valid_nxt;
  logic [DIGITS*4-1:0] bcd_r;
  logic [PAD_BITS-1:0] bin_r;
  logic                neg_r;
  logic [DIGITS*4-1:0] bcd_v;
  logic [PAD_BITS-1:0] bin_v;
  logic                load;

  assign up_ready = !valid_r || dn_ready;
  assign load     = up_valid && up_ready;

  // shift-and-add-3 over this stage's slice of the magnitude, msb first
  always_comb begin
    bcd_v = up_bcd;
    bin_v = up_bin;
    for (int j = 0; j < STAGE_BITS; j++) begin
      for (int d = 0; d < DIGITS; d++) begin
        if (bcd_v[d*4 +: 4] >= BCD_ADJ_MIN) begin
          bcd_v[d*4 +: 4] = bcd_v[d*4 +: 4] + BCD_ADJ_ADD;
        end
      end
      bcd_v = {bcd_v[DIGITS*4-2:0], bin_v[PAD_BITS-1]};
      bin_v = {bin_v[PAD_BITS-2:0], 1'b0};
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (up_ready) begin
      valid_nxt = up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bcd_r <= bcd_v;
      bin_r <= bin_v;
      neg_r <= up_neg;
    end
  end

  assign dn_valid = valid_r;
  assign dn_bcd   = bcd_r;
  assign dn_bin   = bin_r;
  assign dn_neg   = neg_r;

endmodule

// ===== design/s2d_serial.sv =====
module s2d_serial
  import s2d_pkg::*;
#(
  parameter int DIGITS = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  logic [DIGITS*4-1:0] up_bcd,
  input  logic                up_neg,
  output logic                out_valid,
  output logic [CHAR_W-1:0]   out_char_code,
  output logic                out_last_char
);

  localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  logic                active_r;
  logic                active_nxt;
  logic                sign_r;
  logic                sign_nxt;
  logic [IDX_W-1:0]    idx_r;
  logic [IDX_W-1:0]    idx_nxt;
  logic [DIGITS*4-1:0] bcd_r;
  logic                out_valid_r;
  logic [CHAR_W-1:0]   out_char_r;
  logic                out_last_r;
  logic                emit;
  logic [CHAR_W-1:0]   emit_char;
  logic                emit_last;
  logic [IDX_W-1:0]    msd;
  logic [3:0]          digit_sel;
  logic                done;
  logic                load;

  // most significant nonzero digit, zero value points at the units digit
  always_comb begin
    msd = '0;
    for (int d = 0; d < DIGITS; d++) begin
      if (up_bcd[d*4 +: 4] != 4'd0) begin
        msd = IDX_W'(d);
      end
    end
  end

  assign digit_sel = bcd_r[idx_r*4 +: 4];
  assign done      = active_r && !sign_r && (idx_r == '0);
  assign up_ready  = !active_r || done;
  assign load      = up_valid && up_ready;

  always_comb begin
    active_nxt = active_r;
    sign_nxt   = sign_r;
    idx_nxt    = idx_r;
    if (active_r && !sign_r) begin
      if (done) begin
        active_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r - {{(IDX_W-1){1'b0}}, 1'b1};
      end
    end
    if (active_r && sign_r) begin
      sign_nxt = 1'b0;
    end
    if (load) begin
      active_nxt = 1'b1;
      sign_nxt   = up_neg;
      idx_nxt    = msd;
    end
  end

  always_comb begin
    emit      = active_r;
    emit_char = CHAR_MINUS;
    emit_last = 1'b0;
    if (active_r && !sign_r) begin
      emit_char = CHAR_ZERO + {{(CHAR_W-4){1'b0}}, digit_sel};
      emit_last = (idx_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      sign_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      sign_r      <= sign_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bcd_r <= up_bcd;
    end
    out_char_r <= emit_char;
    out_last_r <= emit_last;
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last_char = out_last_r;

endmodule

// ===== design/signed_int_to_decimal_ascii_core.sv =====
// path: an accepted input passes the sign register, the dabble stage registers, the serializer
//   state and the output register; characters of one number are contiguous
// throughput: one character per cycle while a number is being emitted, set by the single-character
//   output register; a number is 1 to 11 characters at 32 bits (sign plus digits)
// reset: synchronous active-low rst_n empties every stage; results cannot be stalled,
//   out_valid marks each character for exactly one cycle
module signed_int_to_decimal_ascii_core
  import s2d_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [VALUE_BITS-1:0] in_value,
  output logic                         out_valid,
  output logic [CHAR_W-1:0]            out_char_code,
  output logic                         out_last_char
);

  // number of double-dabble stages, each retiring STAGE_BITS magnitude bits
  localparam int NSTG = (VALUE_BITS + STAGE_BITS - 1) / STAGE_BITS;
  // magnitude padded with leading zeros to a whole number of stages
  localparam int PAD_BITS = NSTG * STAGE_BITS;
  // enough decimal digits for the largest magnitude, floor(bits * log10 2) + 1
  localparam int DIGITS = (VALUE_BITS * 30103) / 100000 + 1;

  // stage k hands off to stage k+1; index 0 is the sign/magnitude register
  logic [DIGITS*4-1:0] bcd_s   [NSTG+1];
  logic [PAD_BITS-1:0] bin_s   [NSTG+1];
  logic                neg_s   [NSTG+1];
  logic                valid_s [NSTG+1];
  // rdy_s[k] is the input ready of dabble stage k, rdy_s[NSTG] of the serializer
  logic                rdy_s   [NSTG+1];

  // stage 0: sign capture and two's complement magnitude
  s2d_sign #(
    .VALUE_BITS (VALUE_BITS),
    .PAD_BITS   (PAD_BITS)
  ) u_sign (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_value (in_value),
    .busy     (busy),
    .dn_valid (valid_s[0]),
    .dn_ready (rdy_s[0]),
    .dn_mag   (bin_s[0]),
    .dn_neg   (neg_s[0])
  );

  // bcd accumulator starts empty
  assign bcd_s[0] = '0;

  // binary to bcd, STAGE_BITS shift-and-add-3 steps per register stage;
  // each stage holds its item while the next one is full, so nothing is dropped
  for (genvar k = 0; k < NSTG; k++) begin : g_dabble
    s2d_dabble #(
      .DIGITS   (DIGITS),
      .PAD_BITS (PAD_BITS)
    ) u_dabble (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (valid_s[k]),
      .up_ready (rdy_s[k]),
      .up_bcd   (bcd_s[k]),
      .up_bin   (bin_s[k]),
      .up_neg   (neg_s[k]),
      .dn_valid (valid_s[k+1]),
      .dn_ready (rdy_s[k+1]),
      .dn_bcd   (bcd_s[k+1]),
      .dn_bin   (bin_s[k+1]),
      .dn_neg   (neg_s[k+1])
    );
  end

  // character serializer: optional minus, then digits from the leading nonzero one (units for zero);
  // the next number loads in the cycle its predecessor's last digit enters the output register
  s2d_serial #(
    .DIGITS (DIGITS)
  ) u_serial (
    .clk           (clk),
    .rst_n         (rst_n),
    .up_valid      (valid_s[NSTG]),
    .up_ready      (rdy_s[NSTG]),
    .up_bcd        (bcd_s[NSTG]),
    .up_neg        (neg_s[NSTG]),
    .out_valid     (out_valid),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char)
  );

  // a minus sign is never the end of a number
  a_minus_not_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_char_code == CHAR_MINUS)) |-> !out_last_char)
    else $error("minus sign marked as last character");

  // characters of one number leave without gaps
  a_no_gap : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_char) |=> out_valid)
    else $error("gap inside a number's text");

  // every character is a minus sign or a decimal digit
  a_char_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_char_code == CHAR_MINUS) ||
                   ((out_char_code >= CHAR_ZERO) && (out_char_code <= CHAR_ZERO + 6'd9))))
    else $error("character code out of range");

  // busy only when the entry stage holds an item that cannot move on
  a_busy_full : assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (valid_s[0] && !rdy_s[0]))
    else $error("busy with an empty entry stage");

endmodule

// ===== dv/tb_signed_int_to_decimal_ascii_core.sv =====
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii_core;
  import s2d_pkg::*;

  localparam int VALUE_BITS = 32;
  // generous cycle budget, far above the slowest clean run
  localparam int CYCLE_LIMIT = 200000;
  localparam int REPORT_MAX = 10;
  localparam int ITEMS_PER_PHASE = 34;
  localparam int NUM_DIRECTED = 20;

  // one expected output character
  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  // tracks the decimal text every accepted number must produce
  class ascii_text_tracker;
    text_char_t pending_chars[$];
    int mismatches;
    int chars_checked;

    function new();
      mismatches = 0;
      chars_checked = 0;
    endfunction

    // predict the characters of one accepted number
    function void add_number(logic signed [VALUE_BITS-1:0] v);
      logic [VALUE_BITS:0] mag;
      logic [3:0]          digits[$];
      text_char_t          ch;
      // one bit wider magnitude so the most negative value survives
      if (v[VALUE_BITS-1]) begin
        mag = {1'b0, ~v} + 1'b1;
      end else begin
        mag = {1'b0, v};
      end
      do begin
        digits.push_front(4'(mag % 10));
        mag = mag / 10;
      end while (mag != 0);
      if (v[VALUE_BITS-1]) begin
        ch.code = CHAR_MINUS;
        ch.last = 1'b0;
        pending_chars.push_back(ch);
      end
      foreach (digits[i]) begin
        ch.code = CHAR_ZERO + CHAR_W'(digits[i]);
        ch.last = (i == digits.size() - 1);
        pending_chars.push_back(ch);
      end
    endfunction

    // compare one output character against the oldest prediction
    function void check_char(logic [CHAR_W-1:0] code, logic last);
      text_char_t want;
      chars_checked++;
      if (pending_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected char: code %0d last %0b", code, last);
        return;
      end
      want = pending_chars.pop_front();
      if (want.code !== code || want.last !== last) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("char mismatch: expected code %0d last %0b, got code %0d last %0b",
                   want.code, want.last, code, last);
      end
    endfunction

    function int pending();
      return pending_chars.size();
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  logic signed [VALUE_BITS-1:0] in_value;
  logic                         out_valid;
  logic [CHAR_W-1:0]            out_char_code;
  logic                         out_last_char;

  ascii_text_tracker board;
  int cycle_count;
  int numbers_sent;

  signed_int_to_decimal_ascii_core #(
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_char_code(out_char_code),
    .out_last_char(out_last_char)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // input transfer: start high while busy low at the rising edge
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      board.add_number(in_value);
      numbers_sent++;
    end
  end

  // every strobed character is checked, the receiver has no stall
  always @(posedge clk) begin
    if (rst_n && out_valid)
      board.check_char(out_char_code, out_last_char);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d chars still pending",
               cycle_count, board.pending());
      $display("tb_signed_int_to_decimal_ascii_core: done, errors");
      $finish;
    end
  end

  // present one number, idling first with the given chance, return after its transfer
  task automatic send_value(input logic signed [VALUE_BITS-1:0] v, input int idle_pct);
    int gap;
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 6) : 0;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start    <= 1'b1;
    in_value <= v;
    // start stays high until the block takes it
    do @(posedge clk); while (busy);
  endtask

  // stop sending and let every predicted character come out
  task automatic drain_text();
    @(negedge clk);
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // random number with a spread of digit counts, plus raw 32-bit patterns
  function automatic logic signed [VALUE_BITS-1:0] random_value();
    longint lo;
    longint hi;
    longint mag;
    int     ndig;
    bit     neg;
    if ($urandom_range(0, 3) == 0)
      return $urandom;
    ndig = $urandom_range(1, 10);
    neg  = 1'($urandom_range(0, 1));
    lo = 1;
    repeat (ndig - 1) lo = lo * 10;
    hi = lo * 10 - 1;
    if (ndig == 1) lo = 0;
    if (hi > 64'sd2147483647) hi = neg ? 64'sd2147483648 : 64'sd2147483647;
    mag = lo + (longint'({$urandom}) % (hi - lo + 1));
    return neg ? VALUE_BITS'(-mag) : VALUE_BITS'(mag);
  endfunction

  logic signed [VALUE_BITS-1:0] directed_values[NUM_DIRECTED] = '{
    32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100,
    -32'sd5, 32'sd7, 32'sd2147483647, -32'sd2147483647, 32'h8000_0000,
    32'sd1000000000, -32'sd999999999, 32'sd123456789, 32'h5555_5555,
    32'hAAAA_AAAA, -32'sd1000000000, 32'sd999999999
  };

  // sender idle chance for each random phase
  int phase_idle[3] = '{12, 55, 0};

  initial begin
    board        = new();
    cycle_count  = 0;
    numbers_sent = 0;
    rst_n    = 1'b0;
    start    = 1'b0;
    in_value = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // extremes, zero, single digits and decade boundaries
    foreach (directed_values[i])
      send_value(directed_values[i], 12);
    drain_text();

    // random numbers in three idle phases, fully drained between them
    foreach (phase_idle[p]) begin
      repeat (ITEMS_PER_PHASE)
        send_value(random_value(), phase_idle[p]);
      drain_text();
    end

    // tail of the pipeline, nothing further may come out
    repeat (20) @(posedge clk);

    if (board.pending() != 0) begin
      board.mismatches++;
      $display("%0d predicted chars never came out", board.pending());
    end
    $display("converted %0d numbers into %0d checked chars", numbers_sent,
             board.chars_checked);
    $display("covered zero, both extremes, every digit count, three idle phases");
    if (board.mismatches == 0) begin
      $display("tb_signed_int_to_decimal_ascii_core: done, clean");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("tb_signed_int_to_decimal_ascii_core: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/s2d_pkg.sv
design/s2d_sign.sv
design/s2d_dabble.sv
design/s2d_serial.sv
design/signed_int_to_decimal_ascii_core.sv
dv/tb_signed_int_to_decimal_ascii_core.sv
